// ----- rtl/core/rpc_pkg.sv -----
// Shared types and constants of the rectangular/polar converter.
package rpc_pkg;

  // Operation codes carried with each item.
  localparam logic OP_TO_POLAR = 1'b0;
  localparam logic OP_TO_RECT  = 1'b1;

  // Field widths of the channels.
  localparam int IN_W   = 16;
  localparam int MAG_W  = 17;
  localparam int OUT_W  = 16;

  // Angle width inside the datapath: a full circle is 2^32.
  localparam int ZW = 32;

  // Guard bits on the CORDIC x and y words above the fraction bits.
  localparam int X_GUARD = 19;

  // Square root of a 32-bit sum of squares, two radicand bits per step.
  localparam int SQW        = 32;
  localparam int SQRT_STEPS = 16;

  // Width of the gain-correction product and the gain constant itself.
  localparam int PW = 51;
  localparam logic signed [33:0] INV_GAIN = 34'sh0_9B74_EDA8;

  // Arctangent table, atan(2^-i) in units of 2^-32 of a full circle.
  localparam int ATAN_ENTRIES = 30;
  localparam logic [ZW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Control bits that travel with every item.
  typedef struct packed {
    logic op;
    logic zero;
  } rpc_ctrl_t;

endpackage

// ----- rtl/core/rpc_prep.sv -----
// Front end: squares, gain product and quadrant fold, then start values.
module rpc_prep #(
  parameter int DW = 16,
  localparam int XW = DW + rpc_pkg::X_GUARD
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic signed [rpc_pkg::IN_W-1:0]  in_first_value,
  input  logic signed [rpc_pkg::IN_W-1:0]  in_second_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rpc_pkg::rpc_ctrl_t               out_ctrl,
  output logic signed [XW-1:0]             out_x,
  output logic signed [XW-1:0]             out_y,
  output logic [rpc_pkg::ZW-1:0]           out_z,
  output logic [rpc_pkg::SQW-1:0]          out_rem,
  output logic [rpc_pkg::SQW-1:0]          out_root
);

  // First register stage: products and folded start values.
  logic                             v0_r;
  rpc_pkg::rpc_ctrl_t               ctrl0_r, ctrl0_nxt;
  logic [rpc_pkg::SQW-1:0]          sq_re_r, sq_re_nxt;
  logic [rpc_pkg::SQW-1:0]          sq_im_r, sq_im_nxt;
  logic signed [rpc_pkg::IN_W:0]    a_r, a_nxt;
  logic signed [rpc_pkg::IN_W:0]    b_r, b_nxt;
  logic [rpc_pkg::ZW-1:0]           z0_r, z0_nxt;
  logic signed [rpc_pkg::PW-1:0]    prod_r, prod_nxt;

  // Second register stage: CORDIC and square root start values.
  logic                             v1_r;
  rpc_pkg::rpc_ctrl_t               ctrl1_r;
  logic signed [XW-1:0]             x1_r, x1_nxt;
  logic signed [XW-1:0]             y1_r, y1_nxt;
  logic [rpc_pkg::ZW-1:0]           z1_r;
  logic [rpc_pkg::SQW-1:0]          s1_r, s1_nxt;

  logic                             ready0, ready1;
  logic signed [rpc_pkg::SQW-1:0]   sq_re_s, sq_im_s;
  logic signed [rpc_pkg::IN_W:0]    re_ext, im_ext;
  logic                             re_neg, flip;
  logic [rpc_pkg::ZW-1:0]           zp;
  logic signed [rpc_pkg::PW-1:0]    prod_sh;

  assign ready1   = !v1_r || out_ready;
  assign ready0   = !v0_r || ready1;
  assign in_ready = ready0;

  // Squares, quadrant fold and the gain-correction product.
  always_comb begin
    re_ext    = {in_first_value[rpc_pkg::IN_W-1], in_first_value};
    im_ext    = {in_second_value[rpc_pkg::IN_W-1], in_second_value};
    sq_re_s   = in_first_value * in_first_value;
    sq_im_s   = in_second_value * in_second_value;
    sq_re_nxt = sq_re_s;
    sq_im_nxt = sq_im_s;
    re_neg    = in_first_value[rpc_pkg::IN_W-1];
    // A phase beyond a quarter circle is turned by a half circle.
    flip      = (in_second_value > 16'sd16384) || (in_second_value < -16'sd16384);
    zp        = {in_second_value, {(rpc_pkg::ZW - rpc_pkg::IN_W){1'b0}}};
    ctrl0_nxt.op   = in_operation;
    ctrl0_nxt.zero = (in_first_value == '0) && (in_second_value == '0);
    b_nxt     = '0;
    if (in_operation == rpc_pkg::OP_TO_RECT) begin
      a_nxt  = flip ? -re_ext : re_ext;
      z0_nxt = zp ^ {flip, {(rpc_pkg::ZW - 1){1'b0}}};
    end else begin
      // A vector in the left half-plane is turned by a half circle.
      a_nxt  = re_neg ? -re_ext : re_ext;
      b_nxt  = re_neg ? -im_ext : im_ext;
      z0_nxt = {re_neg, {(rpc_pkg::ZW - 1){1'b0}}};
    end
    prod_nxt = a_nxt * rpc_pkg::INV_GAIN;
  end

  // Sum of squares and scaled start vector.
  always_comb begin
    s1_nxt  = sq_re_r + sq_im_r;
    prod_sh = prod_r >>> (32 - DW);
    if (ctrl0_r.op == rpc_pkg::OP_TO_RECT) begin
      x1_nxt = XW'(prod_sh);
      y1_nxt = '0;
    end else begin
      x1_nxt = XW'(a_r) <<< DW;
      y1_nxt = XW'(b_r) <<< DW;
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (ready0) begin
        v0_r <= in_valid;
      end
      if (ready1) begin
        v1_r <= v0_r;
      end
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk) begin
    if (in_valid && ready0) begin
      ctrl0_r <= ctrl0_nxt;
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      z0_r    <= z0_nxt;
      prod_r  <= prod_nxt;
    end
    if (v0_r && ready1) begin
      ctrl1_r <= ctrl0_r;
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      z1_r    <= z0_r;
      s1_r    <= s1_nxt;
    end
  end

  assign out_valid = v1_r;
  assign out_ctrl  = ctrl1_r;
  assign out_x     = x1_r;
  assign out_y     = y1_r;
  assign out_z     = z1_r;
  assign out_rem   = s1_r;
  assign out_root  = '0;

endmodule

// ----- rtl/core/rpc_stage.sv -----
// One pipeline stage: a CORDIC micro-rotation and a square root step.
module rpc_stage #(
  parameter int DW    = 16,
  parameter int STAGE = 0,
  parameter int ITER  = 16,
  localparam int XW = DW + rpc_pkg::X_GUARD
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rpc_pkg::rpc_ctrl_t      in_ctrl,
  input  logic signed [XW-1:0]    in_x,
  input  logic signed [XW-1:0]    in_y,
  input  logic [rpc_pkg::ZW-1:0]  in_z,
  input  logic [rpc_pkg::SQW-1:0] in_rem,
  input  logic [rpc_pkg::SQW-1:0] in_root,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rpc_pkg::rpc_ctrl_t      out_ctrl,
  output logic signed [XW-1:0]    out_x,
  output logic signed [XW-1:0]    out_y,
  output logic [rpc_pkg::ZW-1:0]  out_z,
  output logic [rpc_pkg::SQW-1:0] out_rem,
  output logic [rpc_pkg::SQW-1:0] out_root
);

  localparam int SQ_SHIFT = (STAGE < rpc_pkg::SQRT_STEPS) ?
                            (rpc_pkg::SQW - 2 - 2 * STAGE) : 0;
  localparam logic [rpc_pkg::SQW:0] SQ_BIT = (rpc_pkg::SQW + 1)'(1) << SQ_SHIFT;

  logic                    valid_r;
  rpc_pkg::rpc_ctrl_t      ctrl_r;
  logic signed [XW-1:0]    x_r, x_nxt;
  logic signed [XW-1:0]    y_r, y_nxt;
  logic [rpc_pkg::ZW-1:0]  z_r, z_nxt;
  logic [rpc_pkg::SQW-1:0] rem_r, rem_nxt;
  logic [rpc_pkg::SQW-1:0] root_r, root_nxt;

  assign in_ready = !valid_r || out_ready;

  // Micro-rotation: the sign of y steers vectoring, the sign of z rotation.
  if (STAGE < ITER) begin : g_cordic
    logic                 sigma;
    logic signed [XW-1:0] xs, ys;
    always_comb begin
      xs    = in_x >>> STAGE;
      ys    = in_y >>> STAGE;
      sigma = (in_ctrl.op == rpc_pkg::OP_TO_RECT) ? !in_z[rpc_pkg::ZW-1]
                                                  : in_y[XW-1];
      if (sigma) begin
        x_nxt = in_x - ys;
        y_nxt = in_y + xs;
        z_nxt = in_z - rpc_pkg::ATAN_TAB[STAGE];
      end else begin
        x_nxt = in_x + ys;
        y_nxt = in_y - xs;
        z_nxt = in_z + rpc_pkg::ATAN_TAB[STAGE];
      end
    end
  end else begin : g_cordic_pass
    assign x_nxt = in_x;
    assign y_nxt = in_y;
    assign z_nxt = in_z;
  end

  // Restoring square root step on the remainder and the partial root.
  if (STAGE < rpc_pkg::SQRT_STEPS) begin : g_sqrt
    logic [rpc_pkg::SQW:0] trial;
    logic                  take;
    always_comb begin
      trial = {1'b0, in_root} + SQ_BIT;
      take  = ({1'b0, in_rem} >= trial);
      if (take) begin
        rem_nxt  = in_rem - trial[rpc_pkg::SQW-1:0];
        root_nxt = (in_root >> 1) + SQ_BIT[rpc_pkg::SQW-1:0];
      end else begin
        rem_nxt  = in_rem;
        root_nxt = in_root >> 1;
      end
    end
  end else begin : g_sqrt_pass
    assign rem_nxt  = in_rem;
    assign root_nxt = in_root;
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctrl_r <= in_ctrl;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_ctrl  = ctrl_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;

endmodule

// ----- rtl/core/rpc_post.sv -----
// Back end: rounding, saturation, result selection and output register.
module rpc_post #(
  parameter int DW = 16,
  localparam int XW = DW + rpc_pkg::X_GUARD
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rpc_pkg::rpc_ctrl_t                in_ctrl,
  input  logic signed [XW-1:0]              in_x,
  input  logic signed [XW-1:0]              in_y,
  input  logic [rpc_pkg::ZW-1:0]            in_z,
  input  logic [rpc_pkg::SQW-1:0]           in_rem,
  input  logic [rpc_pkg::SQW-1:0]           in_root,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rpc_pkg::MAG_W-1:0]  out_result_first,
  output logic signed [rpc_pkg::OUT_W-1:0]  out_result_second
);

  localparam logic signed [XW-1:0] HALF   = XW'(1) <<< (DW - 1);
  localparam logic signed [XW-1:0] SAT_HI = XW'(32767);
  localparam logic signed [XW-1:0] SAT_LO = XW'(-32768);
  localparam logic [rpc_pkg::ZW-1:0] PH_HALF = rpc_pkg::ZW'(32768);

  logic                              valid_r;
  logic signed [rpc_pkg::MAG_W-1:0]  first_r, first_nxt;
  logic signed [rpc_pkg::OUT_W-1:0]  second_r, second_nxt;

  logic signed [XW-1:0]              xr, yr;
  logic signed [rpc_pkg::OUT_W-1:0]  xs, ys;
  logic [rpc_pkg::MAG_W-1:0]         mag;
  logic [rpc_pkg::ZW-1:0]            ph;

  assign in_ready = !valid_r || out_ready;

  // Round half up, saturate, and pick the fields for the operation.
  always_comb begin
    xr  = (in_x + HALF) >>> DW;
    yr  = (in_y + HALF) >>> DW;
    xs  = (xr > SAT_HI) ? 16'sh7FFF : ((xr < SAT_LO) ? 16'sh8000 : xr[rpc_pkg::OUT_W-1:0]);
    ys  = (yr > SAT_HI) ? 16'sh7FFF : ((yr < SAT_LO) ? 16'sh8000 : yr[rpc_pkg::OUT_W-1:0]);
    // The root is rounded up when the remainder exceeds it.
    mag = in_root[rpc_pkg::MAG_W-1:0] + rpc_pkg::MAG_W'(in_rem > in_root);
    ph  = in_z + PH_HALF;
    if (in_ctrl.op == rpc_pkg::OP_TO_RECT) begin
      first_nxt  = rpc_pkg::MAG_W'(xs);
      second_nxt = ys;
    end else if (in_ctrl.zero) begin
      first_nxt  = '0;
      second_nxt = '0;
    end else begin
      first_nxt  = mag;
      second_nxt = ph[rpc_pkg::ZW-1 -: rpc_pkg::OUT_W];
    end
  end

  // Output register valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_first  = first_r;
  assign out_result_second = second_r;

`ifndef SYNTHESIS
  // A zero vector converted to polar form comes out as all zeros.
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_ctrl.op == rpc_pkg::OP_TO_POLAR && in_ctrl.zero)
    |=> (out_valid && out_result_first == '0 && out_result_second == '0))
    else $error("zero vector did not give zero magnitude and phase");

  // A magnitude is never negative and never beyond the largest possible one.
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_ctrl.op == rpc_pkg::OP_TO_POLAR)
    |=> (!out_result_first[rpc_pkg::MAG_W-1] && out_result_first <= 17'sd46341))
    else $error("magnitude out of range");

  // A stalled output register keeps its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(first_r) && $stable(second_r)))
    else $error("output register changed while stalled");
`endif

endmodule

// ----- rtl/core/rect_polar_converter_top.sv -----
// Registers in order: the front-end stages, the chain stages and the output register.
// Throughput: one transfer per cycle while the output is ready; every stage carries its own valid bit.
// The depth is set by the longer of the CORDIC chain and the 16-step square root.
// A stall at the output fills bubbles first; input ready drops only when all stages hold items.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
module rect_polar_converter_top #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [rpc_pkg::IN_W-1:0]   in_first_value,
  input  logic signed [rpc_pkg::IN_W-1:0]   in_second_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rpc_pkg::MAG_W-1:0]  out_result_first,
  output logic signed [rpc_pkg::OUT_W-1:0]  out_result_second
);

  localparam int XW       = DATA_WIDTH + rpc_pkg::X_GUARD;
  localparam int ITER_EFF = (ITERATIONS < rpc_pkg::ATAN_ENTRIES) ?
                            ITERATIONS : rpc_pkg::ATAN_ENTRIES;
  localparam int NSTAGE   = (ITER_EFF > rpc_pkg::SQRT_STEPS) ?
                            ITER_EFF : rpc_pkg::SQRT_STEPS;

  // Signals between consecutive stages; index k feeds stage k.
  logic                    st_valid [NSTAGE+1];
  logic                    st_ready [NSTAGE+1];
  rpc_pkg::rpc_ctrl_t      st_ctrl  [NSTAGE+1];
  logic signed [XW-1:0]    st_x     [NSTAGE+1];
  logic signed [XW-1:0]    st_y     [NSTAGE+1];
  logic [rpc_pkg::ZW-1:0]  st_z     [NSTAGE+1];
  logic [rpc_pkg::SQW-1:0] st_rem   [NSTAGE+1];
  logic [rpc_pkg::SQW-1:0] st_root  [NSTAGE+1];

  // Products, quadrant fold and start values.
  rpc_prep #(
    .DW (DATA_WIDTH)
  ) u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .out_valid       (st_valid[0]),
    .out_ready       (st_ready[0]),
    .out_ctrl        (st_ctrl[0]),
    .out_x           (st_x[0]),
    .out_y           (st_y[0]),
    .out_z           (st_z[0]),
    .out_rem         (st_rem[0]),
    .out_root        (st_root[0])
  );

  // Chain of micro-rotation and square root stages.
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    rpc_stage #(
      .DW    (DATA_WIDTH),
      .STAGE (k),
      .ITER  (ITER_EFF)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_ctrl   (st_ctrl[k]),
      .in_x      (st_x[k]),
      .in_y      (st_y[k]),
      .in_z      (st_z[k]),
      .in_rem    (st_rem[k]),
      .in_root   (st_root[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_ctrl  (st_ctrl[k+1]),
      .out_x     (st_x[k+1]),
      .out_y     (st_y[k+1]),
      .out_z     (st_z[k+1]),
      .out_rem   (st_rem[k+1]),
      .out_root  (st_root[k+1])
    );
  end

  // Rounding, saturation and the output register.
  rpc_post #(
    .DW (DATA_WIDTH)
  ) u_post (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (st_valid[NSTAGE]),
    .in_ready          (st_ready[NSTAGE]),
    .in_ctrl           (st_ctrl[NSTAGE]),
    .in_x              (st_x[NSTAGE]),
    .in_y              (st_y[NSTAGE]),
    .in_z              (st_z[NSTAGE]),
    .in_rem            (st_rem[NSTAGE]),
    .in_root           (st_root[NSTAGE]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_first  (out_result_first),
    .out_result_second (out_result_second)
  );

`ifndef SYNTHESIS
  // The input side only stalls behind a result that waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // With the output free, the pipeline always takes a new item.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output is free");

  // A transfer into a pipeline that is held stays counted at the last stage.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid[NSTAGE] && !st_ready[NSTAGE]) |=> st_valid[NSTAGE])
    else $error("last stage lost an item under stall");
`endif

endmodule

// ----- tb/sv/rect_polar_converter_top_test.sv -----
// Self-checking testbench for the rectangular/polar converter with a built-in CORDIC predictor.
`timescale 1ns / 1ps

module rect_polar_converter_top_test;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int PIPE_LATENCY = 19;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 363;
  localparam int CYCLE_LIMIT  = 200000;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint GAIN_CORR = 64'sh9B74EDA8;

  // One expected conversion result.
  typedef struct {
    logic signed [rpc_pkg::MAG_W-1:0] first;
    logic signed [rpc_pkg::OUT_W-1:0] second;
  } conv_result_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic                             op;
    logic signed [rpc_pkg::IN_W-1:0]  first;
    logic signed [rpc_pkg::IN_W-1:0]  second;
    bit                               has_fixed;
    logic signed [rpc_pkg::MAG_W-1:0] fixed_first;
    logic signed [rpc_pkg::OUT_W-1:0] fixed_second;
  } stim_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic                              in_operation;
  logic signed [rpc_pkg::IN_W-1:0]   in_first_value;
  logic signed [rpc_pkg::IN_W-1:0]   in_second_value;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [rpc_pkg::MAG_W-1:0]  out_result_first;
  logic signed [rpc_pkg::OUT_W-1:0]  out_result_second;

  // Side channel travelling with the payload: a hand-typed expectation.
  bit                                row_has_fixed;
  logic signed [rpc_pkg::MAG_W-1:0]  row_fixed_first;
  logic signed [rpc_pkg::OUT_W-1:0]  row_fixed_second;

  conv_result_t pending_results[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_ack = 0;
  int hold_left = 0;
  int error_count;
  int polar_count;
  int rect_count;
  int results_checked;
  int input_stall_cycles;
  int cycle_count = 0;

  rect_polar_converter_top #(
    .DATA_WIDTH(FRAC_BITS),
    .ITERATIONS(CORDIC_STEPS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_first_value   (in_first_value),
    .in_second_value  (in_second_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_first (out_result_first),
    .out_result_second(out_result_second)
  );

  // Free-running clock, 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Clamp a value to the signed 16-bit range.
  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Magnitude (rounded square root) and CORDIC vectoring phase of re + j*im.
  function automatic conv_result_t polar_of(input longint re, input longint im);
    conv_result_t r;
    longint sum_sq, root, trial, x, y, z, nx, ph;
    r.first  = '0;
    r.second = '0;
    if (re == 0 && im == 0) return r;
    sum_sq = re * re + im * im;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    if (sum_sq - root * root > root) root++;
    x = re <<< FRAC_BITS;
    y = im <<< FRAC_BITS;
    z = 0;
    // A vector in the left half-plane is turned by pi first.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(rpc_pkg::ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(rpc_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    ph = (z + 32768) >>> 16;
    r.first  = root[rpc_pkg::MAG_W-1:0];
    r.second = ph[rpc_pkg::OUT_W-1:0];
    return r;
  endfunction

  // Gain-corrected CORDIC rotation of a signed magnitude by a binary angle.
  function automatic conv_result_t rect_of(input longint m, input longint p);
    conv_result_t r;
    longint x, y, z, nx, half, re, im;
    half = longint'(1) << (FRAC_BITS - 1);
    z = p * 65536;
    // Phases past a quarter turn are folded back by pi with the magnitude negated.
    if (p > 16384 || p < -16384) begin
      m = -m;
      z = z + ((z < 0) ? HALF_TURN : -HALF_TURN);
    end
    x = (m * GAIN_CORR) >>> (32 - FRAC_BITS);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(rpc_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(rpc_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    re = clamp16((x + half) >>> FRAC_BITS);
    im = clamp16((y + half) >>> FRAC_BITS);
    r.first  = re[rpc_pkg::MAG_W-1:0];
    r.second = im[rpc_pkg::OUT_W-1:0];
    return r;
  endfunction

  // Draw a field value with extra weight on corners and small magnitudes.
  function automatic logic signed [rpc_pkg::IN_W-1:0] pick_value();
    logic signed [rpc_pkg::IN_W-1:0] corners[8];
    corners = '{-32768, 32767, 0, -1, 1, 16384, -16384, 16385};
    case ($urandom_range(7))
      0:       return corners[$urandom_range(7)];
      1:       return $signed(16'($urandom_range(64))) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item, idling first at the current sender rate, and wait for its transfer.
  task automatic send_item(input logic op, input logic signed [rpc_pkg::IN_W-1:0] a,
                           input logic signed [rpc_pkg::IN_W-1:0] b, input bit has_fixed,
                           input logic signed [rpc_pkg::MAG_W-1:0] f1,
                           input logic signed [rpc_pkg::OUT_W-1:0] f2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_first_value   <= a;
    in_second_value  <= b;
    row_has_fixed    <= has_fixed;
    row_fixed_first  <= f1;
    row_fixed_second <= f2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input back until every outstanding result has come out.
  task automatic wait_drained();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Record the expectation of each input transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (row_has_fixed) begin
        pending_results.push_back('{row_fixed_first, row_fixed_second});
      end else if (in_operation == rpc_pkg::OP_TO_POLAR) begin
        pending_results.push_back(polar_of(in_first_value, in_second_value));
      end else begin
        pending_results.push_back(rect_of(in_first_value, in_second_value));
      end
      if (in_operation == rpc_pkg::OP_TO_POLAR) polar_count++;
      else rect_count++;
    end
    if (rst_n && in_valid && !in_ready) input_stall_cycles++;
  end

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk) begin
    conv_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, got first %0d second %0d",
                 $time, out_result_first, out_result_second);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_first !== exp_r.first) begin
          error_count++;
          $display("%0t: result_first mismatch: expected %0d, got %0d",
                   $time, exp_r.first, out_result_first);
        end
        if (out_result_second !== exp_r.second) begin
          error_count++;
          $display("%0t: result_second mismatch: expected %0d, got %0d",
                   $time, exp_r.second, out_result_second);
        end
      end
      results_checked++;
    end
  end

  // Output back-pressure: long hold-offs on request, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_ready <= 1'b0;
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main sequence: reset, directed table, paced random phases, final check.
  initial begin
    stim_row_t rows[25];
    int idle_plan[4];
    int stall_plan[4];
    logic op;
    rows = '{
      // Rectangular to polar: zero vector, axes, corners, left half-plane.
      '{rpc_pkg::OP_TO_POLAR,      0,      0, 1, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,  32767,      0, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR, -32768,      0, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,      0,  32767, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,      0, -32768, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR, -32768, -32768, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,  32767,  32767, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR, -32768,  32767, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,     -1,      0, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,     -1,     -1, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,      1,      1, 0, 0, 0},
      '{rpc_pkg::OP_TO_POLAR,      3,      4, 0, 0, 0},
      // Polar to rectangular: zero magnitude, saturation, quarter-turn boundaries, pi.
      '{rpc_pkg::OP_TO_RECT,       0,      0, 1, 0, 0},
      '{rpc_pkg::OP_TO_RECT,       0, -32768, 1, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767,      0, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,  -32768,      0, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767,  16384, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767,  16385, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767, -16384, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767, -16385, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767, -32768, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,  -32768, -32768, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,   32767,   8192, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,  -32768,  24576, 0, 0, 0},
      '{rpc_pkg::OP_TO_RECT,    1000,  12345, 0, 0, 0}
    };
    idle_plan  = '{0, 70,  0, 36};
    stall_plan = '{0,  0, 70, 36};

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = rpc_pkg::OP_TO_POLAR;
    in_first_value   = '0;
    in_second_value  = '0;
    row_has_fixed    = 1'b0;
    row_fixed_first  = '0;
    row_fixed_second = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req         = 0;
    error_count      = 0;
    polar_count      = 0;
    rect_count       = 0;
    results_checked  = 0;
    input_stall_cycles = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, back to back with a ready receiver.
    foreach (rows[k]) begin
      send_item(rows[k].op, rows[k].first, rows[k].second, rows[k].has_fixed,
                rows[k].fixed_first, rows[k].fixed_second);
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases with different pacing on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      // The first phase opens with a long output hold-off to fill the pipeline.
      if (ph == 0) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = $urandom_range(1) ? rpc_pkg::OP_TO_RECT : rpc_pkg::OP_TO_POLAR;
        send_item(op, pick_value(), pick_value(), 1'b0, '0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Let any stray output show up before the verdict.
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count += pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("Converted %0d rectangular-to-polar and %0d polar-to-rectangular transfers",
             polar_count, rect_count);
    $display("over four pacing phases; %0d results checked, input stalled %0d cycles",
             results_checked, input_stall_cycles);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rpc_pkg.sv
rtl/core/rpc_prep.sv
rtl/core/rpc_stage.sv
rtl/core/rpc_post.sv
rtl/core/rect_polar_converter_top.sv
tb/sv/rect_polar_converter_top_test.sv
